// ----- rtl/bced_pkg.sv -----
package bced_pkg;

   localparam int TIME_BITS_DEFAULT = 32;

   localparam int NOW_BITS       = 32;
   localparam int REQ_TDATA_BITS = 40;
   localparam int RSP_TDATA_BITS = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_INVERT_LEVEL = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLICK_MIN    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLICK_MAX    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DBL_MIN      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DBL_MAX      = 3'd4;

   typedef struct packed {
      logic double_click_evt;
      logic click_evt;
      logic release_evt;
      logic press_evt;
      logic changed;
      logic level_out;
   } result_type;

   localparam int RESULT_BITS = $bits(result_type);

endpackage

// ----- rtl/button_click_event_detector.sv -----
// A request passes through the input register and then the result register before rsp_tvalid.
// Throughput: one request per cycle while rsp_tready is not held low; the detector state
// updates as a request moves from the input register into the result register.
// Reset (synchronous, active high): configuration registers clear to zero, both
// stages empty, the next request publishes its level unconditionally.
module button_click_event_detector
   import bced_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,  // raw_level, now_ms[31:0], zero pad
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,  // level_out, changed, press_evt,
                                                 // release_evt, click_evt,
                                                 // double_click_evt, zero pad
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic                 invert_level;
   logic [TIME_BITS-1:0] click_min_ms;
   logic [TIME_BITS-1:0] click_max_ms;
   logic [TIME_BITS-1:0] dbl_min_ms;
   logic [TIME_BITS-1:0] dbl_max_ms;

   logic                in_valid_ff;
   logic                raw_level_ff;
   logic [NOW_BITS-1:0] now_ms_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_ff;
   result_type          result;
   logic                advance;
   logic                req_take;

   bced_csr #(.TIME_BITS(TIME_BITS)) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .invert_level (invert_level),
      .click_min_ms (click_min_ms),
      .click_max_ms (click_max_ms),
      .dbl_min_ms   (dbl_min_ms),
      .dbl_max_ms   (dbl_max_ms)
   );

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   bced_core #(.TIME_BITS(TIME_BITS)) u_core (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .raw_level    (raw_level_ff),
      .now_ms       (now_ms_ff),
      .invert_level (invert_level),
      .click_min_ms (click_min_ms),
      .click_max_ms (click_max_ms),
      .dbl_min_ms   (dbl_min_ms),
      .dbl_max_ms   (dbl_max_ms),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= req_take || (in_valid_ff && !advance);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         raw_level_ff <= req_tdata[0];
         now_ms_ff    <= req_tdata[NOW_BITS:1];
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_BITS - RESULT_BITS){1'b0}}, rsp_ff};

   a_event_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_ff.press_evt || rsp_ff.release_evt) == rsp_ff.changed)
                     && !(rsp_ff.press_evt && rsp_ff.release_evt))
      else $error("press/release do not match changed");

   a_click_on_fall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.click_evt) |-> (rsp_ff.release_evt && !rsp_ff.level_out))
      else $error("click without a fall");

   a_dbl_on_rise: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.double_click_evt) |-> (rsp_ff.press_evt && rsp_ff.level_out))
      else $error("double click without a rise");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(now_ms_ff)))
      else $error("input register dropped a stalled request");

endmodule

// ----- rtl/bced_window.sv -----
module bced_window
   import bced_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic [TIME_BITS-1:0] lo,
   input  logic [TIME_BITS-1:0] hi,
   input  logic [TIME_BITS-1:0] len,
   output logic                 hit
);

   // zero upper bound means no limit
   assign hit = (len >= lo) && ((hi == '0) || (len <= hi));

endmodule

// ----- rtl/bced_csr.sv -----
module bced_csr
   import bced_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output logic                      invert_level,
   output logic [TIME_BITS-1:0]      click_min_ms,
   output logic [TIME_BITS-1:0]      click_max_ms,
   output logic [TIME_BITS-1:0]      dbl_min_ms,
   output logic [TIME_BITS-1:0]      dbl_max_ms
);

   logic                 invert_level_ff;
   logic [TIME_BITS-1:0] click_min_ff;
   logic [TIME_BITS-1:0] click_max_ff;
   logic [TIME_BITS-1:0] dbl_min_ff;
   logic [TIME_BITS-1:0] dbl_max_ff;
   logic [TIME_BITS-1:0] wdata_time;

   assign wdata_time = TIME_BITS'(csr_wdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_level_ff <= 1'b0;
         click_min_ff    <= '0;
         click_max_ff    <= '0;
         dbl_min_ff      <= '0;
         dbl_max_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INVERT_LEVEL: invert_level_ff <= csr_wdata[0];
            CSR_CLICK_MIN:    click_min_ff    <= wdata_time;
            CSR_CLICK_MAX:    click_max_ff    <= wdata_time;
            CSR_DBL_MIN:      dbl_min_ff      <= wdata_time;
            CSR_DBL_MAX:      dbl_max_ff      <= wdata_time;
            default: begin
            end
         endcase
      end
   end

   assign invert_level = invert_level_ff;
   assign click_min_ms = click_min_ff;
   assign click_max_ms = click_max_ff;
   assign dbl_min_ms   = dbl_min_ff;
   assign dbl_max_ms   = dbl_max_ff;

endmodule

// ----- rtl/bced_core.sv -----
module bced_core
   import bced_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 raw_level,
   input  logic [NOW_BITS-1:0]  now_ms,
   input  logic                 invert_level,
   input  logic [TIME_BITS-1:0] click_min_ms,
   input  logic [TIME_BITS-1:0] click_max_ms,
   input  logic [TIME_BITS-1:0] dbl_min_ms,
   input  logic [TIME_BITS-1:0] dbl_max_ms,
   output result_type           result
);

   logic                 first_pending_ff, first_pending_in;
   logic                 last_level_ff, last_level_in;
   logic [TIME_BITS-1:0] click_start_ff, click_start_in;
   logic [TIME_BITS-1:0] edge_prev_ff, edge_prev_in;
   logic [TIME_BITS-1:0] edge_last_ff, edge_last_in;

   logic                 level;
   logic [TIME_BITS-1:0] now;
   logic [TIME_BITS-1:0] click_len;
   logic [TIME_BITS-1:0] press_len;
   logic [TIME_BITS-1:0] gap_len;
   logic                 click_hit;
   logic                 press_hit;
   logic                 gap_hit;
   logic                 change;
   logic                 dbl;

   assign level     = raw_level ^ invert_level;
   assign now       = TIME_BITS'(now_ms);
   assign click_len = now - click_start_ff;
   assign press_len = edge_last_ff - edge_prev_ff;
   assign gap_len   = now - edge_last_ff;

   bced_window #(.TIME_BITS(TIME_BITS)) u_click_win (
      .lo  (click_min_ms),
      .hi  (click_max_ms),
      .len (click_len),
      .hit (click_hit)
   );

   bced_window #(.TIME_BITS(TIME_BITS)) u_press_win (
      .lo  (dbl_min_ms),
      .hi  (dbl_max_ms),
      .len (press_len),
      .hit (press_hit)
   );

   bced_window #(.TIME_BITS(TIME_BITS)) u_gap_win (
      .lo  (dbl_min_ms),
      .hi  (dbl_max_ms),
      .len (gap_len),
      .hit (gap_hit)
   );

   assign change = first_pending_ff || (level != last_level_ff);
   assign dbl    = change && level && (edge_prev_ff != '0) && (edge_last_ff != '0)
                   && press_hit && gap_hit;

   always_comb begin
      first_pending_in = first_pending_ff;
      last_level_in    = last_level_ff;
      click_start_in   = click_start_ff;
      edge_prev_in     = edge_prev_ff;
      edge_last_in     = edge_last_ff;
      if (change) begin
         first_pending_in = 1'b0;
         last_level_in    = level;
         if (level) begin
            click_start_in = now;
         end
         if (dbl) begin
            edge_prev_in = '0;
            edge_last_in = '0;
         end else begin
            edge_prev_in = edge_last_ff;
            edge_last_in = now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_pending_ff <= 1'b1;
         last_level_ff    <= 1'b0;
         click_start_ff   <= '0;
         edge_prev_ff     <= '0;
         edge_last_ff     <= '0;
      end else if (advance) begin
         first_pending_ff <= first_pending_in;
         last_level_ff    <= last_level_in;
         click_start_ff   <= click_start_in;
         edge_prev_ff     <= edge_prev_in;
         edge_last_ff     <= edge_last_in;
      end
   end

   always_comb begin
      result.level_out        = last_level_in;
      result.changed          = change;
      result.press_evt        = change && level;
      result.release_evt      = change && !level;
      result.click_evt        = change && !level && click_hit;
      result.double_click_evt = dbl;
   end

endmodule

// ----- test/button_click_event_checker.sv -----
module button_click_event_checker
   import bced_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        mismatches,
   output int                        outstanding,
   output int                        clicks_seen,
   output int                        doubles_seen
);

   logic                invert_on;
   logic [NOW_BITS-1:0] click_lo, click_hi, dbl_lo, dbl_hi;

   logic                publish_next;
   logic                held_level;
   logic [NOW_BITS-1:0] press_time, older_edge, newer_edge;

   result_type expected_events[$];

   function automatic logic in_limits(input logic [NOW_BITS-1:0] lo,
                                      input logic [NOW_BITS-1:0] hi,
                                      input logic [NOW_BITS-1:0] span);
      if (hi == '0) return span >= lo;
      return (span >= lo) && (span <= hi);
   endfunction

   task automatic publish_level(input logic raw, input logic [NOW_BITS-1:0] now,
                                output result_type ev);
      logic lvl;
      lvl = raw ^ invert_on;
      ev = '0;
      if (publish_next || lvl != held_level) begin
         publish_next = 1'b0;
         held_level   = lvl;
         ev.changed   = 1'b1;
         if (lvl) begin
            ev.press_evt = 1'b1;
            press_time   = now;
         end else begin
            ev.release_evt = 1'b1;
            ev.click_evt   = in_limits(click_lo, click_hi, now - press_time);
         end
         if (lvl && older_edge != '0 && newer_edge != '0 &&
             in_limits(dbl_lo, dbl_hi, newer_edge - older_edge) &&
             in_limits(dbl_lo, dbl_hi, now - newer_edge)) begin
            ev.double_click_evt = 1'b1;
            older_edge = '0;
            newer_edge = '0;
         end else begin
            older_edge = newer_edge;
            newer_edge = now;
         end
      end
      ev.level_out = held_level;
   endtask

   always @(posedge clock) begin
      result_type ev;
      result_type got;
      int         errs;
      int         clicks;
      int         doubles;
      errs    = 0;
      clicks  = 0;
      doubles = 0;
      if (reset) begin
         invert_on    = 1'b0;
         click_lo     = '0;
         click_hi     = '0;
         dbl_lo       = '0;
         dbl_hi       = '0;
         publish_next = 1'b1;
         held_level   = 1'b0;
         press_time   = '0;
         older_edge   = '0;
         newer_edge   = '0;
         expected_events.delete();
         mismatches   <= 0;
         clicks_seen  <= 0;
         doubles_seen <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_INVERT_LEVEL: invert_on = csr_wdata[0];
               CSR_CLICK_MIN:    click_lo  = csr_wdata[NOW_BITS-1:0];
               CSR_CLICK_MAX:    click_hi  = csr_wdata[NOW_BITS-1:0];
               CSR_DBL_MIN:      dbl_lo    = csr_wdata[NOW_BITS-1:0];
               CSR_DBL_MAX:      dbl_hi    = csr_wdata[NOW_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[RESULT_BITS-1:0]);
            if (expected_events.size() == 0) begin
               $display("%0t: response %b with no request outstanding", $time, got);
               errs++;
            end else begin
               ev = expected_events.pop_front();
               if (got !== ev) begin
                  $display("%0t: mismatch expected lvl=%b chg=%b prs=%b rel=%b clk=%b dbl=%b",
                           $time, ev.level_out, ev.changed, ev.press_evt,
                           ev.release_evt, ev.click_evt, ev.double_click_evt);
                  $display("%0t:          actual   lvl=%b chg=%b prs=%b rel=%b clk=%b dbl=%b",
                           $time, got.level_out, got.changed, got.press_evt,
                           got.release_evt, got.click_evt, got.double_click_evt);
                  errs++;
               end
            end
            clicks  = (got.click_evt === 1'b1) ? 1 : 0;
            doubles = (got.double_click_evt === 1'b1) ? 1 : 0;
         end
         if (req_tvalid && req_tready) begin
            publish_level(req_tdata[0], req_tdata[NOW_BITS:1], ev);
            expected_events.push_back(ev);
         end
         mismatches   <= mismatches + errs;
         clicks_seen  <= clicks_seen + clicks;
         doubles_seen <= doubles_seen + doubles;
      end
      outstanding <= expected_events.size();
   end

endmodule

// ----- test/tb_button_click_event_detector.sv -----
module tb_button_click_event_detector;
   import bced_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_UNUSED = CSR_DBL_MAX + 1'b1;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   int mismatches, outstanding, clicks_seen, doubles_seen;
   int gap_pct, stall_pct;
   int cycle_count = 0;
   int requests_sent, settings_used;

   button_click_event_detector uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   button_click_event_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .outstanding  (outstanding),
      .clicks_seen  (clicks_seen),
      .doubles_seen (doubles_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready  <= ($urandom_range(99) >= stall_pct);
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_button_click_event_detector: FAIL");
         $finish;
      end
   end

   task automatic send_request(input logic raw, input logic [NOW_BITS-1:0] now);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_BITS-NOW_BITS-1){1'b0}}, now, raw};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
   endtask

   // hold off until every response is back, then let the pipeline settle
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic inv, input logic [31:0] cmin,
                               input logic [31:0] cmax, input logic [31:0] dmin,
                               input logic [31:0] dmax);
      logic [CSR_DATA_BITS-1:0] noise;
      noise = $urandom;
      write_csr(CSR_INVERT_LEVEL, {noise[CSR_DATA_BITS-1:1], inv});
      write_csr(CSR_CLICK_MIN, cmin);
      write_csr(CSR_CLICK_MAX, cmax);
      write_csr(CSR_DBL_MIN, dmin);
      write_csr(CSR_DBL_MAX, dmax);
      if ($urandom_range(1))
         write_csr(CSR_FIRST_UNUSED + CSR_INDEX_BITS'($urandom_range(2)), $urandom);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   initial begin
      logic [NOW_BITS-1:0] stamp;
      logic                level;
      logic [31:0]         cmin, cmax, dmin, dmax;
      int                  r;
      gap_pct       = 0;
      stall_pct     = 0;
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      csr_we        <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      requests_sent = 0;
      settings_used = 1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(1'b0, 32'd5);
      send_request(1'b0, 32'd6);
      send_request(1'b1, 32'd100);
      send_request(1'b1, 32'd120);
      send_request(1'b0, 32'd150);
      send_request(1'b1, 32'd200);
      send_request(1'b0, 32'd0);
      send_request(1'b1, 32'd0);
      send_request(1'b0, 32'hFFFF_FFFF);
      send_request(1'b1, 32'h0000_0010);
      send_request(1'b0, 32'hFFFF_FFF0);
      drain();
      program_regs(1'b1, 32'd10, 32'd50, 32'd20, 32'd100);
      send_request(1'b0, 32'd1000);
      send_request(1'b1, 32'd1030);
      send_request(1'b0, 32'd1080);
      send_request(1'b1, 32'd1200);
      send_request(1'b0, 32'd1205);
      send_request(1'b1, 32'd1210);
      send_request(1'b0, 32'd1300);
      send_request(1'b1, 32'd1320);
      send_request(1'b0, 32'd1400);
      send_request(1'b1, 32'd1400);

      for (int seg = 0; seg < 8; seg++) begin
         drain();
         cmin = $urandom_range(60);
         cmax = cmin + $urandom_range(150);
         dmin = $urandom_range(60);
         dmax = dmin + $urandom_range(150);
         case (seg)
            0: program_regs(1'b0, 32'd0, 32'd0, 32'd0, 32'd0);
            2: program_regs(1'b0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
            3: program_regs(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF);
            5: program_regs(1'($urandom_range(1)), cmin, 32'd0, dmin, 32'd0);
            default: program_regs(1'($urandom_range(1)), cmin, cmax, dmin, dmax);
         endcase
         case (seg % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 54; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 54; end
            default: begin gap_pct = 19; stall_pct = 19; end
         endcase
         stamp = seg[0] ? 32'hFFFF_FF00 + $urandom_range(255) : $urandom_range(1000);
         level = 1'($urandom_range(1));
         for (int n = 0; n < 180; n++) begin
            r = $urandom_range(99);
            if (r < 45)      stamp = stamp + $urandom_range(60);
            else if (r < 82) stamp = stamp + $urandom_range(300);
            else if (r < 88) stamp = stamp;
            else if (r < 93) stamp = $urandom;
            else if (r < 96) stamp = stamp - 1'b1;
            else             stamp = '0;
            if ($urandom_range(99) < 60) level = ~level;
            send_request(level, stamp);
         end
      end

      gap_pct   = 0;
      stall_pct = 0;
      drain();
      $display("tb_button_click_event_detector: %0d requests across %0d register settings",
               requests_sent, settings_used);
      $display("  four idling mixes; responses carried %0d clicks, %0d double clicks",
               clicks_seen, doubles_seen);
      if (mismatches == 0) begin
         $display("tb_button_click_event_detector: PASS");
      end else begin
         $display("tb_button_click_event_detector: FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/bced_pkg.sv
rtl/bced_window.sv
rtl/bced_csr.sv
rtl/bced_core.sv
rtl/button_click_event_detector.sv
test/button_click_event_checker.sv
test/tb_button_click_event_detector.sv
